// ----- rtl/core/point_in_polygon_ray_cast_defines.svh -----
// Assertion macros shared by the point-in-polygon RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PIPR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipr assertion failed");
// Next-cycle implication.
`define PIPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipr assertion failed");
`else
`define PIPR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PIPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/pipr_pkg.sv -----
// Shared types and codes for the point-in-polygon classifier.
// No dependencies; imported by pipr_cross and point_in_polygon_ray_cast.
package pipr_pkg;

  // Status of the shared cross-product unit.
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } pipr_xstat_t;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  localparam logic [1:0] REL_INSIDE   = 2'd0;
  localparam logic [1:0] REL_BOUNDARY = 2'd1;
  localparam logic [1:0] REL_OUTSIDE  = 2'd2;

endpackage

// ----- rtl/core/pipr_cross.sv -----
// Shared cross-product unit: (p1 - p0) x (p2 - p0) with one multiplier.
// Depends on pipr_pkg for the status struct.
module pipr_cross import pipr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_BITS:0]     p1x,
  input  logic signed [COORD_BITS:0]     p1y,
  input  logic signed [COORD_BITS:0]     p2x,
  input  logic signed [COORD_BITS:0]     p2y,
  input  logic signed [COORD_BITS:0]     p0x,
  input  logic signed [COORD_BITS:0]     p0y,
  output pipr_xstat_t                    stat,
  output logic signed [2*COORD_BITS+4:0] xprod
);

  localparam int CW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MUL_A = 2'd1;
  localparam logic [1:0] PH_MUL_B = 2'd2;
  localparam logic [1:0] PH_SUB   = 2'd3;

  logic [1:0]           phase;
  logic                 done;
  logic signed [DW-1:0] d1, d2, d3, d4;
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] mul;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] hold;

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [DW-1:0] ae;
    logic signed [DW-1:0] be;
    ae = {a[CW-1], a};
    be = {b[CW-1], b};
    return ae - be;
  endfunction

  // One multiplier, operands steered by phase.
  assign ma  = (phase == PH_MUL_A) ? d1 : d3;
  assign mb  = (phase == PH_MUL_A) ? d2 : d4;
  assign mul = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_MUL_A: phase <= PH_MUL_B;
        PH_MUL_B: phase <= PH_SUB;
        PH_SUB: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: phase <= PH_IDLE;
      endcase
      if (start) begin
        phase <= PH_MUL_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d1 <= diff(p1x, p0x);
      d2 <= diff(p2y, p0y);
      d3 <= diff(p2x, p0x);
      d4 <= diff(p1y, p0y);
    end
    if (phase == PH_MUL_A) begin
      prod <= mul;
    end
    if (phase == PH_MUL_B) begin
      hold <= prod;
      prod <= mul;
    end
    if (phase == PH_SUB) begin
      xprod <= XW'({hold[PW-1], hold}) - XW'({prod[PW-1], prod});
    end
  end

  assign stat.done = done;
  assign stat.neg  = xprod[XW-1];
  assign stat.zero = (xprod == '0);

endmodule

// ----- rtl/core/point_in_polygon_ray_cast.sv -----
// Point-in-polygon classifier by crossing number, with boundary detection.
// A start item (cmd = 0) loads the query point Q and clears the parity and
// boundary flags. Vertex items (cmd = 1) then stream in one at a time; each
// vertex after the first tests the edge from the previous vertex, and the
// vertex marked last_vertex also tests the closing edge back to the first
// vertex and is the only item that yields a result: relation 0 inside,
// 1 on the boundary, 2 outside. A leftward ray from Q ends at a finite x one
// below the coordinate range. All tests are exact integer arithmetic: every
// cross product goes through one shared multiplier (pipr_cross), two products
// and a subtract, one cross product at a time. An edge needs one to seven
// cross products, depending on which early exit it takes (on boundary,
// horizontal, endpoint on the ray, bounding boxes apart, straddle tests).
// in_ready is low while an item is being worked on; the result sits in an
// output register, and the block waits at the end of a polygon only if an
// earlier result has not yet been taken. collinear_tolerance is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this. A cross product or
// edge height of magnitude below it counts as zero. No clearing pass after
// reset.
`include "point_in_polygon_ray_cast_defines.svh"

module point_in_polygon_ray_cast import pipr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   relation
);

  localparam int CW = COORD_BITS + 1;
  localparam int XW = 2 * (COORD_BITS + 2) + 1;

  // Ray end: -(2^(COORD_BITS-1)) - 1, one below the coordinate range.
  localparam logic signed [CW-1:0] RAY_X = {2'b10, {(COORD_BITS-1){1'b1}}};

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EDGE = 4'd1;
  localparam logic [3:0] S_CQ   = 4'd2;
  localparam logic [3:0] S_CA   = 4'd3;
  localparam logic [3:0] S_CB   = 4'd4;
  localparam logic [3:0] S_S1   = 4'd5;
  localparam logic [3:0] S_S2   = 4'd6;
  localparam logic [3:0] S_S3   = 4'd7;
  localparam logic [3:0] S_S4   = 4'd8;
  localparam logic [3:0] S_NEXT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // Cross-product operand sets, named p1 p2 p0.
  localparam logic [2:0] XP_ABQ = 3'd0;
  localparam logic [2:0] XP_QRA = 3'd1;
  localparam logic [2:0] XP_QRB = 3'd2;
  localparam logic [2:0] XP_ARQ = 3'd3;
  localparam logic [2:0] XP_RBQ = 3'd4;
  localparam logic [2:0] XP_QBA = 3'd5;
  localparam logic [2:0] XP_BRA = 3'd6;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [15:0] tol;

  // Architectural state.
  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [COORD_BITS-1:0] fx, fy;
  logic signed [COORD_BITS-1:0] px, py;
  logic                         parity;
  logic                         bound;
  logic                         seen;

  // Edge under test and sequencing flags.
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic                         closing_pending;
  logic                         closing_active;
  logic                         s1_neg, s1_zero;

  // Shared unit interface.
  logic                 x_start;
  logic [2:0]           x_op;
  logic signed [CW-1:0] p1x, p1y, p2x, p2y, p0x, p0y;
  pipr_xstat_t          xs;
  logic signed [XW-1:0] xcross;

  logic signed [CW-1:0] qxe, qye, axe, aye, bxe, bye;
  logic signed [CW-1:0] hdiff;
  logic signed [XW-1:0] hwide;
  logic                 small_c, horiz;
  logic                 on_q, on_a, on_b;
  logic                 bbox_miss;
  logic                 opposite;
  logic                 par_flip;
  logic                 bound_set;
  logic                 out_fire;

  function automatic logic is_small(input logic signed [XW-1:0] v,
                                    input logic [15:0] t);
    logic signed [XW-1:0] tw;
    logic signed [XW-1:0] s;
    tw = {{(XW-16){1'b0}}, t};
    s  = v + tw;
    return v[XW-1] ? (s > 0) : (v < tw);
  endfunction

  function automatic logic between(input logic signed [CW-1:0] v,
                                   input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b);
    return (a <= b) ? (a <= v && v <= b) : (b <= v && v <= a);
  endfunction

  function automatic logic signed [CW-1:0] max2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign qxe = {qx[COORD_BITS-1], qx};
  assign qye = {qy[COORD_BITS-1], qy};
  assign axe = {ax[COORD_BITS-1], ax};
  assign aye = {ay[COORD_BITS-1], ay};
  assign bxe = {bx[COORD_BITS-1], bx};
  assign bye = {by[COORD_BITS-1], by};

  // Edge height, widened so the same tolerance test applies.
  assign hdiff = aye - bye;
  assign hwide = {{(XW-CW){hdiff[CW-1]}}, hdiff};
  assign horiz = is_small(hwide, tol);

  assign small_c = is_small(xcross, tol);
  assign on_q = small_c && between(qxe, axe, bxe) && between(qye, aye, bye);
  assign on_a = small_c && between(axe, qxe, RAY_X) && (aye == qye);
  assign on_b = small_c && between(bxe, qxe, RAY_X) && (bye == qye);

  // Bounding boxes of ray Q-R and edge A-B must overlap.
  assign bbox_miss = (max2(qxe, RAY_X) < min2(axe, bxe))
                  || (max2(axe, bxe) < min2(qxe, RAY_X))
                  || (qye < min2(aye, bye))
                  || (max2(aye, bye) < qye);

  // Held sign against the sign just produced: strictly opposite.
  assign opposite = (s1_neg && !xs.neg && !xs.zero)
                 || (!s1_neg && !s1_zero && xs.neg);

  // Operand steering for the shared unit.
  always_comb begin
    p1x = qxe;  p1y = qye;
    p2x = RAY_X; p2y = qye;
    p0x = axe;  p0y = aye;
    case (x_op)
      XP_ABQ: begin
        p1x = axe; p1y = aye; p2x = bxe; p2y = bye; p0x = qxe; p0y = qye;
      end
      XP_QRA: begin
        p1x = qxe; p1y = qye; p2x = RAY_X; p2y = qye; p0x = axe; p0y = aye;
      end
      XP_QRB: begin
        p1x = qxe; p1y = qye; p2x = RAY_X; p2y = qye; p0x = bxe; p0y = bye;
      end
      XP_ARQ: begin
        p1x = axe; p1y = aye; p2x = RAY_X; p2y = qye; p0x = qxe; p0y = qye;
      end
      XP_RBQ: begin
        p1x = RAY_X; p1y = qye; p2x = bxe; p2y = bye; p0x = qxe; p0y = qye;
      end
      XP_QBA: begin
        p1x = qxe; p1y = qye; p2x = bxe; p2y = bye; p0x = axe; p0y = aye;
      end
      XP_BRA: begin
        p1x = bxe; p1y = bye; p2x = RAY_X; p2y = qye; p0x = axe; p0y = aye;
      end
      default: ;
    endcase
  end

  pipr_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (x_start),
    .p1x   (p1x),
    .p1y   (p1y),
    .p2x   (p2x),
    .p2y   (p2y),
    .p0x   (p0x),
    .p0y   (p0y),
    .stat  (xs),
    .xprod (xcross)
  );

  assign in_ready = (state == S_IDLE);
  assign out_fire = (state == S_OUT) && (!out_valid || out_ready);

  // Sequencer: launch the next cross product in the cycle the previous one lands.
  always_comb begin
    state_next = state;
    x_start    = 1'b0;
    x_op       = XP_ABQ;
    par_flip   = 1'b0;
    bound_set  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && cmd == CMD_VERTEX && (last_vertex || seen)) begin
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        x_start    = 1'b1;
        x_op       = XP_ABQ;
        state_next = S_CQ;
      end
      S_CQ: begin
        if (xs.done) begin
          if (on_q) begin
            bound_set  = 1'b1;
            state_next = S_NEXT;
          end else if (horiz) begin
            state_next = S_NEXT;
          end else begin
            x_start    = 1'b1;
            x_op       = XP_QRA;
            state_next = S_CA;
          end
        end
      end
      S_CA: begin
        if (xs.done) begin
          if (on_a) begin
            par_flip   = (ay > by);
            state_next = S_NEXT;
          end else begin
            x_start    = 1'b1;
            x_op       = XP_QRB;
            state_next = S_CB;
          end
        end
      end
      S_CB: begin
        if (xs.done) begin
          if (on_b) begin
            par_flip   = (by > ay);
            state_next = S_NEXT;
          end else if (bbox_miss) begin
            state_next = S_NEXT;
          end else begin
            x_start    = 1'b1;
            x_op       = XP_ARQ;
            state_next = S_S1;
          end
        end
      end
      S_S1: begin
        if (xs.done) begin
          x_start    = 1'b1;
          x_op       = XP_RBQ;
          state_next = S_S2;
        end
      end
      S_S2: begin
        if (xs.done) begin
          if (opposite) begin
            state_next = S_NEXT;
          end else begin
            x_start    = 1'b1;
            x_op       = XP_QBA;
            state_next = S_S3;
          end
        end
      end
      S_S3: begin
        if (xs.done) begin
          x_start    = 1'b1;
          x_op       = XP_BRA;
          state_next = S_S4;
        end
      end
      S_S4: begin
        if (xs.done) begin
          par_flip   = !opposite;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (closing_pending) begin
          state_next = S_EDGE;
        end else if (closing_active) begin
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tol             <= 16'd1;
      qx              <= '0;
      qy              <= '0;
      fx              <= '0;
      fy              <= '0;
      px              <= '0;
      py              <= '0;
      parity          <= 1'b0;
      bound           <= 1'b0;
      seen            <= 1'b0;
      closing_pending <= 1'b0;
      closing_active  <= 1'b0;
      out_valid       <= 1'b0;
      relation        <= REL_OUTSIDE;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        tol <= cfg_wr_data;
      end
      if (par_flip) begin
        parity <= !parity;
      end
      if (bound_set) begin
        bound <= 1'b1;
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_START) begin
          qx     <= coord_x;
          qy     <= coord_y;
          parity <= 1'b0;
          bound  <= 1'b0;
          seen   <= 1'b0;
        end else begin
          px <= coord_x;
          py <= coord_y;
          if (!seen) begin
            // First vertex: only a one-vertex polygon tests an edge now.
            fx              <= coord_x;
            fy              <= coord_y;
            seen            <= 1'b1;
            closing_pending <= 1'b0;
            closing_active  <= last_vertex;
          end else begin
            closing_pending <= last_vertex;
            closing_active  <= 1'b0;
          end
        end
      end
      if (state == S_NEXT && closing_pending) begin
        closing_pending <= 1'b0;
        closing_active  <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_fire) begin
        out_valid      <= 1'b1;
        relation       <= bound ? REL_BOUNDARY : (parity ? REL_INSIDE : REL_OUTSIDE);
        parity         <= 1'b0;
        bound          <= 1'b0;
        seen           <= 1'b0;
        closing_active <= 1'b0;
      end
    end
  end

  // Edge endpoints and held straddle sign.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cmd == CMD_VERTEX) begin
      if (!seen) begin
        ax <= coord_x;
        ay <= coord_y;
      end else begin
        ax <= px;
        ay <= py;
      end
      bx <= coord_x;
      by <= coord_y;
    end
    if (state == S_NEXT && closing_pending) begin
      // Closing edge: last vertex back to the first.
      ax <= px;
      ay <= py;
      bx <= fx;
      by <= fy;
    end
    if ((state == S_S1 || state == S_S3) && xs.done) begin
      s1_neg  <= xs.neg;
      s1_zero <= xs.zero;
    end
  end

  `PIPR_ASSERT_IMPL(a_idle_unit_quiet, clk, rst, in_ready, !xs.done)
  `PIPR_ASSERT_IMPL(a_done_in_wait, clk, rst, xs.done, (state >= S_CQ) && (state <= S_S4))
  `PIPR_ASSERT_NEXT(a_result_clears, clk, rst, out_fire, out_valid && !seen && !parity && !bound)
  `PIPR_ASSERT_IMPL(a_close_once, clk, rst, closing_pending, !closing_active)

endmodule
